[hdl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent holds, consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/cbwk_pkg.sv]
// shared types and constants of the cycle breaking weight block
package cbwk_pkg;

    localparam int VERTEX_BITS = 10;
    localparam int IN_WEIGHT_BITS = 32;
    localparam int TOTAL_BITS = 44;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_run;
        logic mark;
        logic node_load_a;
        logic node_load_b;
        logic walk;
        logic save_a;
        logic save_b;
        logic add;
        logic merge_child;
        logic merge_root;
        logic finish;
        logic clear_run;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic best_vld;
        logic root_found;
        logic same_root;
        logic clear_last;
    } status_t;

endpackage

[hdl/cbwk_ctrl.sv]
// controller state machine of the cycle breaking weight block
module cbwk_ctrl
    import cbwk_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    last_edge,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN_INIT, S_SCAN, S_MARK, S_FA_RD, S_FA_CHK,
        S_FB_RD, S_FB_CHK, S_JOIN, S_MERGE2, S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_run = 1'b1;
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_edge)
                        state_next = S_SCAN_INIT;
                end
            end
            S_SCAN_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_done)
                    state_next = status.best_vld ? S_MARK : S_RESULT;
            end
            S_MARK:
            begin
                cmd.mark = 1'b1;
                cmd.node_load_a = 1'b1;
                state_next = S_FA_RD;
            end
            S_FA_RD: state_next = S_FA_CHK;
            S_FA_CHK:
            begin
                if (status.root_found)
                begin
                    cmd.save_a = 1'b1;
                    cmd.node_load_b = 1'b1;
                    state_next = S_FB_RD;
                end
                else
                begin
                    cmd.walk = 1'b1;
                    state_next = S_FA_RD;
                end
            end
            S_FB_RD: state_next = S_FB_CHK;
            S_FB_CHK:
            begin
                if (status.root_found)
                begin
                    cmd.save_b = 1'b1;
                    state_next = S_JOIN;
                end
                else
                begin
                    cmd.walk = 1'b1;
                    state_next = S_FB_RD;
                end
            end
            S_JOIN:
            begin
                if (status.same_root)
                begin
                    cmd.add = 1'b1;
                    state_next = S_SCAN_INIT;
                end
                else
                begin
                    cmd.merge_child = 1'b1;
                    state_next = S_MERGE2;
                end
            end
            S_MERGE2:
            begin
                cmd.merge_root = 1'b1;
                state_next = S_SCAN_INIT;
            end
            S_RESULT:
            begin
                cmd.finish = 1'b1;
                state_next = S_CLEAR;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= (state_reg == S_RESULT);
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

[hdl/cbwk_datapath.sv]
// edge store, set forest and accumulator of the cycle breaking weight block
module cbwk_datapath
    import cbwk_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES = 4096,
    parameter int WEIGHT_BITS = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    input  logic [VERTEX_BITS-1:0]        from_vertex,
    input  logic [VERTEX_BITS-1:0]        to_vertex,
    input  logic signed [IN_WEIGHT_BITS-1:0] edge_weight,
    output status_t                       status,
    output logic signed [TOTAL_BITS-1:0]  removed_weight_total,
    output logic                          edges_dropped
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int SW = $clog2(MAX_VERTICES + 1);
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int DW = 1 + 2 * VW + WEIGHT_BITS;

    // vertex number modulo the vertex count, by restoring subtraction
    function automatic logic [VW-1:0] vmod(input logic [VERTEX_BITS-1:0] v);
        int r;
        r = int'(v);
        for (int k = VERTEX_BITS - 1; k >= 0; k--)
            if (r >= (MAX_VERTICES << k))
                r = r - (MAX_VERTICES << k);
        return r[VW-1:0];
    endfunction

    logic [DW-1:0]      edge_mem [MAX_EDGES];
    logic [DW-1:0]      edge_rd_reg;
    logic [VW+SW-1:0]   par_mem [MAX_VERTICES];
    logic [VW+SW-1:0]   par_rd_reg;

    logic [CW-1:0]      count_reg, idx_reg;
    logic               rd_vld_reg, ovf_reg;
    logic [TOTAL_BITS-1:0] total_reg, res_total_reg;
    logic               res_drop_reg;
    logic               best_vld_reg;
    logic [EW-1:0]      best_idx_reg, rd_idx_reg;
    logic [VW-1:0]      best_a_reg, best_b_reg;
    logic signed [WEIGHT_BITS-1:0] best_w_reg;
    logic [VW-1:0]      node_reg, root_a_reg, root_b_reg, clr_idx_reg;
    logic [SW-1:0]      size_a_reg, size_b_reg;

    logic               rd_done;
    logic [VW-1:0]      rd_a, rd_b, rd_parent;
    logic signed [WEIGHT_BITS-1:0] rd_w;
    logic [SW-1:0]      rd_size;
    logic               b_wins;
    logic [VW-1:0]      big_root, small_root;
    logic [SW-1:0]      small_size, size_sum;
    logic               room;

    assign rd_done = edge_rd_reg[DW-1];
    assign rd_a = edge_rd_reg[DW-2 -: VW];
    assign rd_b = edge_rd_reg[DW-2-VW -: VW];
    assign rd_w = $signed(edge_rd_reg[WEIGHT_BITS-1:0]);
    assign rd_parent = par_rd_reg[VW+SW-1 -: VW];
    assign rd_size = par_rd_reg[SW-1:0];

    // on equal sizes the first endpoint's root stays root
    assign b_wins = (size_a_reg < size_b_reg);
    assign big_root = b_wins ? root_b_reg : root_a_reg;
    assign small_root = b_wins ? root_a_reg : root_b_reg;
    assign small_size = b_wins ? size_a_reg : size_b_reg;
    assign size_sum = size_a_reg + size_b_reg;
    assign room = (count_reg < CW'(MAX_EDGES));

    assign status.scan_done = (idx_reg == count_reg) && !rd_vld_reg;
    assign status.best_vld = best_vld_reg;
    assign status.root_found = (rd_parent == node_reg);
    assign status.same_root = (root_a_reg == root_b_reg);
    assign status.clear_last = (clr_idx_reg == VW'(MAX_VERTICES - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
            edge_mem[count_reg[EW-1:0]] <= {1'b0, vmod(from_vertex), vmod(to_vertex),
                                            edge_weight[WEIGHT_BITS-1:0]};
        else if (cmd.mark)
            edge_mem[best_idx_reg] <= {1'b1, best_a_reg, best_b_reg, best_w_reg};
        edge_rd_reg <= edge_mem[idx_reg[EW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_run)
            par_mem[clr_idx_reg] <= {clr_idx_reg, SW'(1)};
        else if (cmd.merge_child)
            par_mem[small_root] <= {big_root, small_size};
        else if (cmd.merge_root)
            par_mem[big_root] <= {big_root, size_sum};
        par_rd_reg <= par_mem[node_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            ovf_reg <= 1'b0;
            total_reg <= '0;
            best_vld_reg <= 1'b0;
            clr_idx_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (room)
                    count_reg <= count_reg + CW'(1);
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.scan_init)
            begin
                idx_reg <= '0;
                rd_vld_reg <= 1'b0;
                best_vld_reg <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                rd_vld_reg <= (idx_reg != count_reg);
                if (idx_reg != count_reg)
                    idx_reg <= idx_reg + CW'(1);
                // keep the heaviest edge not yet taken
                if (rd_vld_reg && !rd_done && (!best_vld_reg || rd_w > best_w_reg))
                    best_vld_reg <= 1'b1;
            end
            if (cmd.add)
                total_reg <= total_reg
                    + {{(TOTAL_BITS-WEIGHT_BITS){best_w_reg[WEIGHT_BITS-1]}}, best_w_reg};
            if (cmd.finish)
            begin
                count_reg <= '0;
                ovf_reg <= 1'b0;
                total_reg <= '0;
                clr_idx_reg <= '0;
            end
            else if (cmd.clear_run)
                clr_idx_reg <= clr_idx_reg + VW'(1);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg[EW-1:0];
        if (cmd.scan_run && rd_vld_reg && !rd_done && (!best_vld_reg || rd_w > best_w_reg))
        begin
            best_idx_reg <= rd_idx_reg;
            best_a_reg <= rd_a;
            best_b_reg <= rd_b;
            best_w_reg <= rd_w;
        end
        if (cmd.node_load_a)
            node_reg <= best_a_reg;
        else if (cmd.node_load_b)
            node_reg <= best_b_reg;
        else if (cmd.walk)
            node_reg <= rd_parent;
        if (cmd.save_a)
        begin
            root_a_reg <= node_reg;
            size_a_reg <= rd_size;
        end
        if (cmd.save_b)
        begin
            root_b_reg <= node_reg;
            size_b_reg <= rd_size;
        end
        if (cmd.finish)
        begin
            res_total_reg <= total_reg;
            res_drop_reg <= ovf_reg;
        end
    end

    assign removed_weight_total = $signed(res_total_reg);
    assign edges_dropped = res_drop_reg;

endmodule

[hdl/cycle_breaking_weight_kruskal.sv]
// top level of the cycle breaking weight block
// Edges are loaded one per cycle (start while busy is low); the edge with last_edge set
// starts the run. The run repeatedly scans the edge store for the heaviest edge not yet
// taken (reading the edges in turn through the single read port of the edge store),
// then walks both parent chains in the set forest (reading and checking each node
// visited, root included) and either adds the weight to the total or merges the sets,
// writing the child entry and then the root entry. The result is shown for one cycle
// on done and cannot be held off; a clearing pass over all MAX_VERTICES entries then
// resets the set forest, also after reset, and busy stays high.
module cycle_breaking_weight_kruskal
    import cbwk_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES = 4096,
    parameter int WEIGHT_BITS = 32
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [VERTEX_BITS-1:0]           from_vertex,
    input  logic [VERTEX_BITS-1:0]           to_vertex,
    input  logic signed [IN_WEIGHT_BITS-1:0] edge_weight,
    input  logic                             last_edge,
    output logic                             done,
    output logic signed [TOTAL_BITS-1:0]     removed_weight_total,
    output logic                             edges_dropped
);

    cmd_t    cmd;
    status_t status;
    logic    busy_int;

    cbwk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_edge (last_edge),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy_int),
        .done      (done)
    );

    cbwk_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .from_vertex          (from_vertex),
        .to_vertex            (to_vertex),
        .edge_weight          (edge_weight),
        .status               (status),
        .removed_weight_total (removed_weight_total),
        .edges_dropped        (edges_dropped)
    );

    assign busy = busy_int;

endmodule

[hdl/cbwk_checker.sv]
// port level checks of the cycle breaking weight block and their binding
`include "assert_macros.svh"

module cbwk_port_checks (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_edge,
    input logic done
);

    // the result comes out while the forest is being cleared
    `ASSERT_SAME(a_done_busy, clk, rst_n, done, busy)
    // a single result per graph
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    // an edge that is not the last one gives no result
    `ASSERT_NEXT(a_no_early_done, clk, rst_n, start && !busy && !last_edge, !done)

endmodule

bind cycle_breaking_weight_kruskal cbwk_port_checks u_cbwk_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .last_edge (last_edge),
    .done      (done)
);
